FILE: hdl/gnl_pkg.sv
// ----------------------------------------------------------------------------
// gnl_pkg: shared types and constants of the grammar notation lexer
// Holds the token kinds, error codes, character codes and the result word.
// ----------------------------------------------------------------------------
package gnl_pkg;

   // Width of the byte position counter and of the token fields
   localparam int POS_BITS = 16;

   // Highest usable offset plus one: a byte arriving here is too far
   localparam logic [POS_BITS-1:0] POS_LIMIT = '1;

   // Token kinds
   localparam logic [3:0] KIND_IDENT   = 4'd0;
   localparam logic [3:0] KIND_STRING  = 4'd1;
   localparam logic [3:0] KIND_ARROW   = 4'd2;
   localparam logic [3:0] KIND_LPAREN  = 4'd3;
   localparam logic [3:0] KIND_RPAREN  = 4'd4;
   localparam logic [3:0] KIND_BAR     = 4'd5;
   localparam logic [3:0] KIND_STOP    = 4'd6;
   localparam logic [3:0] KIND_NEWLINE = 4'd7;
   localparam logic [3:0] KIND_BLANK   = 4'd8;
   localparam logic [3:0] KIND_NONE    = 4'd9;

   // Error codes
   localparam logic [2:0] ERR_OK         = 3'd0;
   localparam logic [2:0] ERR_BAD_BYTE   = 3'd1;
   localparam logic [2:0] ERR_LONE_DASH  = 3'd2;
   localparam logic [2:0] ERR_UNTERM_STR = 3'd3;
   localparam logic [2:0] ERR_TOO_LONG   = 3'd4;

   // Character codes
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_DOLLAR     = 8'h24;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_DASH       = 8'h2D;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_GT         = 8'h3E;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_BAR        = 8'h7C;

   // One result word
   typedef struct packed {
      logic [3:0]          token_kind;
      logic [POS_BITS-1:0] token_start;
      logic [POS_BITS-1:0] token_length;
      logic [2:0]          error_code;
      logic                stream_done;
      logic                run_last;
   } gnl_result_type;

   // Words handed from the lexer step to the result queue
   typedef struct packed {
      logic [1:0]     count;
      gnl_result_type word1;
      gnl_result_type word0;
   } gnl_push_type;

   // Queue status seen by the lexer step
   typedef struct packed {
      logic room;
   } gnl_queue_status_type;

endpackage

FILE: hdl/gnl_if.sv
// ----------------------------------------------------------------------------
// gnl_if: channel interfaces of the grammar notation lexer
// Valid/ready channels for source bytes and for result words.
// ----------------------------------------------------------------------------
interface gnl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       is_end;

   modport source (output valid, output source_byte, output is_end, input ready);
   modport sink   (input valid, input source_byte, input is_end, output ready);
endinterface

interface gnl_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [2:0]  error_code;
   logic        stream_done;
   logic        run_last;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output error_code, output stream_done,
                   output run_last, input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input error_code, input stream_done,
                   input run_last, output ready);
endinterface

FILE: hdl/gnl_lex_step.sv
// ----------------------------------------------------------------------------
// gnl_lex_step: input register and one-byte lexer step
// Registers the incoming byte, then in one pass updates the lexer state and
// produces up to two result words for the queue.
// ----------------------------------------------------------------------------
module gnl_lex_step (
   input  logic                          clock,
   input  logic                          reset,
   gnl_req_if.sink                       req_if,
   input  gnl_pkg::gnl_queue_status_type status,
   output gnl_pkg::gnl_push_type         push
);
   import gnl_pkg::*;

   // Lexer modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_IDENT   = 3'd1;
   localparam logic [2:0] MODE_BLANK   = 3'd2;
   localparam logic [2:0] MODE_NEWLINE = 3'd3;
   localparam logic [2:0] MODE_STRING  = 3'd4;
   localparam logic [2:0] MODE_DASH    = 3'd5;
   localparam logic [2:0] MODE_HALT    = 3'd6;

   function automatic logic f_ident_start(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)
             || b == CH_UNDERSCORE || b == CH_DOLLAR;
   endfunction

   function automatic logic f_is_run(input logic [2:0] m);
      return m == MODE_IDENT || m == MODE_BLANK || m == MODE_NEWLINE;
   endfunction

   function automatic logic f_run_continues(input logic [2:0] m, input logic [7:0] b);
      logic c;
      unique case (m)
         MODE_IDENT: c = f_ident_start(b) || (b >= 8'h30 && b <= 8'h39);
         MODE_BLANK: c = b == CH_SPACE || b == CH_TAB;
         default:    c = b == CH_LF || b == CH_CR;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] f_run_kind(input logic [2:0] m);
      logic [3:0] k;
      unique case (m)
         MODE_IDENT: k = KIND_IDENT;
         MODE_BLANK: k = KIND_BLANK;
         default:    k = KIND_NEWLINE;
      endcase
      return k;
   endfunction

   function automatic gnl_result_type f_word(input logic [3:0] kind,
                                             input logic [POS_BITS-1:0] start,
                                             input logic [POS_BITS-1:0] len,
                                             input logic [2:0] err);
      gnl_result_type w;
      w.token_kind   = kind;
      w.token_start  = start;
      w.token_length = len;
      w.error_code   = err;
      w.stream_done  = 1'b0;
      w.run_last     = 1'b0;
      return w;
   endfunction

   // Input register
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_end_ff;
   logic                step_fire;
   logic                req_take;

   // Lexer state
   logic [2:0]          mode_ff, mode_in;
   logic [POS_BITS-1:0] begin_ff, begin_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic                bs_ff, bs_in;
   logic                bs2_ff, bs2_in;

   // Step outputs
   gnl_result_type      res [2];
   logic [1:0]          res_count;

   assign step_fire     = in_valid_ff && status.room;
   assign req_if.ready  = !in_valid_ff || step_fire;
   assign req_take      = req_if.valid && req_if.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff <= req_if.source_byte;
         in_end_ff  <= req_if.is_end;
      end
   end

   // One lexer step on the registered byte
   always_comb begin
      logic [7:0] b;
      logic       do_start;
      logic       last_idx;
      b         = in_byte_ff;
      do_start  = 1'b0;
      mode_in   = mode_ff;
      begin_in  = begin_ff;
      pos_in    = pos_ff;
      bs_in     = bs_ff;
      bs2_in    = bs2_ff;
      res[0]    = '0;
      res[1]    = '0;
      res_count = 2'd0;

      if (mode_ff != MODE_HALT) begin
         if (pos_ff >= POS_LIMIT) begin
            if (f_is_run(mode_ff)) begin
               res[res_count[0]] = f_word(f_run_kind(mode_ff), begin_ff,
                                          pos_ff - begin_ff, ERR_OK);
               res_count = res_count + 2'd1;
            end
            res[res_count[0]] = f_word(KIND_NONE, pos_ff, '0, ERR_TOO_LONG);
            res_count = res_count + 2'd1;
            mode_in = MODE_HALT;
         end else begin
            priority if (mode_ff == MODE_STRING) begin
               if (b == CH_NUL) begin
                  res[res_count[0]] = f_word(KIND_NONE, begin_ff, '0, ERR_UNTERM_STR);
                  res_count = res_count + 2'd1;
                  mode_in = MODE_HALT;
               end else if (b == CH_QUOTE && (!bs_ff || bs2_ff)) begin
                  res[res_count[0]] = f_word(KIND_STRING, begin_ff,
                                             pos_ff + 1'b1 - begin_ff, ERR_OK);
                  res_count = res_count + 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  bs2_in = bs_ff;
                  bs_in  = (b == CH_BACKSLASH);
               end
            end else if (mode_ff == MODE_DASH) begin
               if (b == CH_GT) begin
                  res[res_count[0]] = f_word(KIND_ARROW, begin_ff, POS_BITS'(2), ERR_OK);
                  res_count = res_count + 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  res[res_count[0]] = f_word(KIND_NONE, begin_ff, '0, ERR_LONE_DASH);
                  res_count = res_count + 2'd1;
                  mode_in = MODE_HALT;
               end
            end else if (f_is_run(mode_ff)) begin
               if (!f_run_continues(mode_ff, b)) begin
                  res[res_count[0]] = f_word(f_run_kind(mode_ff), begin_ff,
                                             pos_ff - begin_ff, ERR_OK);
                  res_count = res_count + 2'd1;
                  mode_in  = MODE_IDLE;
                  do_start = 1'b1;
               end
            end else begin
               do_start = 1'b1;
            end

            // Open a new token on this byte
            if (do_start) begin
               begin_in = pos_ff;
               priority if (b == CH_LF) begin
                  mode_in = MODE_NEWLINE;
               end else if (b == CH_SPACE || b == CH_TAB) begin
                  mode_in = MODE_BLANK;
               end else if (f_ident_start(b)) begin
                  mode_in = MODE_IDENT;
               end else if (b == CH_QUOTE) begin
                  mode_in = MODE_STRING;
                  bs_in   = 1'b0;
                  bs2_in  = 1'b0;
               end else if (b == CH_DOT) begin
                  res[res_count[0]] = f_word(KIND_STOP, pos_ff, POS_BITS'(1), ERR_OK);
                  res_count = res_count + 2'd1;
               end else if (b == CH_LPAREN) begin
                  res[res_count[0]] = f_word(KIND_LPAREN, pos_ff, POS_BITS'(1), ERR_OK);
                  res_count = res_count + 2'd1;
               end else if (b == CH_RPAREN) begin
                  res[res_count[0]] = f_word(KIND_RPAREN, pos_ff, POS_BITS'(1), ERR_OK);
                  res_count = res_count + 2'd1;
               end else if (b == CH_BAR) begin
                  res[res_count[0]] = f_word(KIND_BAR, pos_ff, POS_BITS'(1), ERR_OK);
                  res_count = res_count + 2'd1;
               end else if (b == CH_DASH) begin
                  mode_in = MODE_DASH;
               end else if (b == CH_NUL) begin
                  mode_in = MODE_HALT;
               end else begin
                  res[res_count[0]] = f_word(KIND_NONE, pos_ff, '0, ERR_BAD_BYTE);
                  res_count = res_count + 2'd1;
                  mode_in = MODE_HALT;
               end
            end
            pos_in = pos_ff + 1'b1;
         end
      end

      // End of source: flush the open token and restart
      if (in_end_ff) begin
         if (f_is_run(mode_in)) begin
            res[res_count[0]] = f_word(f_run_kind(mode_in), begin_in,
                                       pos_ff + 1'b1 - begin_in, ERR_OK);
            res_count = res_count + 2'd1;
         end else if (mode_in == MODE_STRING) begin
            res[res_count[0]] = f_word(KIND_NONE, begin_in, '0, ERR_UNTERM_STR);
            res_count = res_count + 2'd1;
         end else if (mode_in == MODE_DASH) begin
            res[res_count[0]] = f_word(KIND_NONE, begin_in, '0, ERR_LONE_DASH);
            res_count = res_count + 2'd1;
         end
         if (res_count == 2'd0) begin
            res[0] = f_word(KIND_NONE, '0, '0, ERR_OK);
            res_count = 2'd1;
         end
         mode_in  = MODE_IDLE;
         begin_in = '0;
         pos_in   = '0;
         bs_in    = 1'b0;
         bs2_in   = 1'b0;
      end

      // Mark the last word of this step
      last_idx = (res_count == 2'd2);
      if (res_count != 2'd0) begin
         res[last_idx].run_last    = 1'b1;
         res[last_idx].stream_done = in_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         begin_ff <= '0;
         pos_ff   <= '0;
         bs_ff    <= 1'b0;
         bs2_ff   <= 1'b0;
      end else if (step_fire) begin
         mode_ff  <= mode_in;
         begin_ff <= begin_in;
         pos_ff   <= pos_in;
         bs_ff    <= bs_in;
         bs2_ff   <= bs2_in;
      end
   end

   assign push.count = step_fire ? res_count : 2'd0;
   assign push.word0 = res[0];
   assign push.word1 = res[1];

endmodule

FILE: hdl/gnl_rsp_queue.sv
// ----------------------------------------------------------------------------
// gnl_rsp_queue: four-word result queue
// Takes up to two words a cycle from the lexer step and hands one word a
// cycle to the result channel while the channel is ready.
// ----------------------------------------------------------------------------
module gnl_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  gnl_pkg::gnl_push_type         push,
   output gnl_pkg::gnl_queue_status_type status,
   gnl_rsp_if.source                     rsp_if
);
   import gnl_pkg::*;

   gnl_result_type q_ff [4];
   logic [1:0]     head_ff, head_in;
   logic [1:0]     tail_ff, tail_in;
   logic [2:0]     count_ff, count_in;
   logic           pop;
   gnl_result_type head_word;

   // Room for a full two-word step
   assign status.room = (count_ff <= 3'd2);

   assign head_word           = q_ff[head_ff];
   assign rsp_if.valid        = (count_ff != 3'd0);
   assign rsp_if.token_kind   = head_word.token_kind;
   assign rsp_if.token_start  = head_word.token_start;
   assign rsp_if.token_length = head_word.token_length;
   assign rsp_if.error_code   = head_word.error_code;
   assign rsp_if.stream_done  = head_word.stream_done;
   assign rsp_if.run_last     = head_word.run_last;

   assign pop      = rsp_if.valid && rsp_if.ready;
   assign head_in  = head_ff + {1'b0, pop};
   assign tail_in  = tail_ff + push.count;
   assign count_in = count_ff + {1'b0, push.count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Word storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[tail_ff] <= push.word0;
      end
      if (push.count == 2'd2) begin
         q_ff[tail_ff + 2'd1] <= push.word1;
      end
   end

endmodule

FILE: hdl/grammar_notation_lexer_unit.sv
// ----------------------------------------------------------------------------
// grammar_notation_lexer_unit: streaming lexer for a grammar notation
// Input register, one-pass lexer step and a result queue.
// ----------------------------------------------------------------------------
// Takes one source byte per clock while the queue has room and returns
// tokens as kind, start offset and length. A byte is held in the input
// register, where the lexer step runs, and its words go to the result
// queue. Most bytes give no word, some give one and a few give two; the
// four-word queue accepts a new byte whenever it holds two words or fewer,
// so with a sink that is always ready the unit takes a byte every cycle
// and only a run of two-word bytes makes it pause. After an error or a
// zero byte nothing more comes out until the end word, which also resets
// the lexer for the next source. Positions count from 0 to 65534.
module grammar_notation_lexer_unit (
   input  logic      clock,
   input  logic      reset,
   gnl_req_if.sink   req_if,
   gnl_rsp_if.source rsp_if
);
   import gnl_pkg::*;

   gnl_push_type         push;
   gnl_queue_status_type status;

   gnl_lex_step u_lex_step (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .status (status),
      .push   (push)
   );

   gnl_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .status (status),
      .rsp_if (rsp_if)
   );

endmodule
